>>> src/sha256_stream_hash_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the SHA-256 stream hash core
// ---------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASH_CORE_MACROS_SVH
`define SHA256_STREAM_HASH_CORE_MACROS_SVH

// implication checked on every clock edge outside reset
`define SHC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// condition that holds at every clock edge outside reset
`define SHC_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define SHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> src/shash_pkg.sv
// ---------------------------------------------------------------------------
// shash_pkg
// Types, constants and functions shared by the SHA-256 stream hash core.
// ---------------------------------------------------------------------------
`default_nettype none
package shash_pkg;

	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam int unsigned LEN_POS  = 56;
	localparam int unsigned ROUNDS   = 64;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct packed {
		logic [7:0] msg_byte;
		logic       byte_present;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// byte source for a buffer write
	typedef enum logic [1:0] {
		WSRC_MSG  = 2'd0,
		WSRC_PAD  = 2'd1,
		WSRC_ZERO = 2'd2,
		WSRC_LEN  = 2'd3
	} wsrc_t;

	// controller to datapath
	typedef struct packed {
		logic        buf_wr;
		wsrc_t       wsrc;
		logic [5:0]  wr_addr;
		logic        count_add;
		logic        load_msg;
		logic        comp_start;
		logic        round_en;
		logic [5:0]  round;
		logic        comp_done;
		logic        init_hash;
		logic [2:0]  out_sel;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [5:0] load_idx;
	} dp_sts_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage
`default_nettype wire

>>> src/shash_stream_if.sv
// ---------------------------------------------------------------------------
// shash_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ---------------------------------------------------------------------------
`default_nettype none
interface shash_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> src/shash_datapath.sv
// ---------------------------------------------------------------------------
// shash_datapath
// Block buffer, bit counter, message schedule, round logic and hash words.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sha256_stream_hash_core_macros.svh"
module shash_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire shash_pkg::dp_cmd_t cmd,
	input  wire logic [7:0]        msg_byte,
	output      shash_pkg::dp_sts_t sts,
	output      logic [31:0]       hash_word
);
	logic [7:0]  buf_q [64];
	logic [63:0] bitcnt_q;
	logic [31:0] w_q [16];
	logic [31:0] h_q [8];
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q;
	logic [5:0]  lidx_q;
	logic [7:0]  rd_q;
	logic [7:0]  wr_byte;
	logic [31:0] w_cur, s0, s1, t1, t2, w_new;

	always_comb begin
		case (cmd.wsrc)
			shash_pkg::WSRC_MSG:  wr_byte = msg_byte;
			shash_pkg::WSRC_PAD:  wr_byte = shash_pkg::PAD_BYTE;
			shash_pkg::WSRC_ZERO: wr_byte = 8'h00;
			shash_pkg::WSRC_LEN:  wr_byte = bitcnt_q[8 * (7 - cmd.wr_addr[2:0]) +: 8];
			default:              wr_byte = 8'h00;
		endcase
	end

	// buffer: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.buf_wr) begin
			buf_q[cmd.wr_addr] <= wr_byte;
		end
		rd_q <= buf_q[lidx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitcnt_q <= '0;
			lidx_q   <= '0;
		end else begin
			if (cmd.count_add) begin
				bitcnt_q <= bitcnt_q + 64'd8;
			end else if (cmd.init_hash) begin
				bitcnt_q <= '0;
			end
			if (cmd.load_msg) begin
				lidx_q <= lidx_q + 6'd1;
			end else begin
				lidx_q <= '0;
			end
		end
	end

	assign sts.load_idx = lidx_q;

	always_comb begin
		s0    = shash_pkg::rotr(w_q[1], 7) ^ shash_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1    = shash_pkg::rotr(w_q[14], 17) ^ shash_pkg::rotr(w_q[14], 19)
			^ (w_q[14] >> 10);
		w_new = s1 + w_q[9] + s0 + w_q[0];
		w_cur = (cmd.round < 6'd16) ? w_q[0] : w_new;
		t1 = hh_q + (shash_pkg::rotr(e_q, 6) ^ shash_pkg::rotr(e_q, 11)
			^ shash_pkg::rotr(e_q, 25)) + ((e_q & f_q) ^ (~e_q & g_q))
			+ shash_pkg::ROUND_K[cmd.round] + w_cur;
		t2 = (shash_pkg::rotr(a_q, 2) ^ shash_pkg::rotr(a_q, 13) ^ shash_pkg::rotr(a_q, 22))
			+ ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
	end

	// schedule window shifts one word per round; w_q[0] is the current word in rounds 0..15, w_new after
	always_ff @(posedge clk) begin
		if (cmd.load_msg && lidx_q != 6'd0) begin
			w_q[15] <= {w_q[15][23:0], rd_q};
			if (lidx_q[1:0] == 2'd1) begin
				for (int i = 0; i < 15; i++) begin
					w_q[i] <= w_q[i + 1];
				end
			end
		end else if (cmd.comp_start) begin
			w_q[15] <= {w_q[15][23:0], rd_q};
		end else if (cmd.round_en) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_cur;
		end
		if (cmd.comp_start) begin
			a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
			e_q <= h_q[4]; f_q <= h_q[5]; g_q <= h_q[6]; hh_q <= h_q[7];
		end else if (cmd.round_en) begin
			hh_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= shash_pkg::INIT_HASH[i];
			end
		end else if (cmd.init_hash) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= shash_pkg::INIT_HASH[i];
			end
		end else if (cmd.comp_done) begin
			h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
			h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
			h_q[4] <= h_q[4] + e_q; h_q[5] <= h_q[5] + f_q;
			h_q[6] <= h_q[6] + g_q; h_q[7] <= h_q[7] + hh_q;
		end
	end

	assign hash_word = h_q[cmd.out_sel];

	`SHC_ASSERT_IMPL(a_no_wr_in_round, clk, arst_n, cmd.round_en, !cmd.buf_wr)
	`SHC_ASSERT_IMPL(a_no_init_in_round, clk, arst_n, cmd.round_en, !cmd.init_hash)
	`SHC_ASSERT_NEXT(a_init_hash, clk, arst_n, cmd.init_hash, h_q[0] == shash_pkg::INIT_HASH[0])
endmodule
`default_nettype wire

>>> src/shash_ctrl.sv
// ---------------------------------------------------------------------------
// shash_ctrl
// Sequencer for byte intake, padding, compression and digest output.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sha256_stream_hash_core_macros.svh"
module shash_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire shash_pkg::in_item_t in_item,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      logic [2:0]         out_idx,
	output      shash_pkg::dp_cmd_t  cmd,
	input  wire shash_pkg::dp_sts_t  sts
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_ROUND, ST_DONE, ST_PAD, ST_OUT
	} state_t;

	state_t     state_q;
	logic [5:0] fill_q;
	logic [5:0] fill_nx;
	logic [5:0] round_q;
	logic       final_q;   // compressing a padded block
	logic       second_q;  // padded block needs a second block
	logic       pad_first_q;
	logic [2:0] oidx_q;
	logic [6:0] lcnt_q;
	logic       pend_end_q;
	logic       acc;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_idx   = oidx_q;

	assign acc     = in_valid && in_ready;
	assign fill_nx = fill_q + {5'd0, in_item.byte_present};

	always_comb begin
		cmd = '0;
		cmd.wsrc     = shash_pkg::WSRC_MSG;
		cmd.wr_addr  = fill_q;
		cmd.round    = round_q;
		cmd.out_sel  = oidx_q;
		case (state_q)
			ST_IDLE: begin
				cmd.buf_wr    = acc && in_item.byte_present;
				cmd.count_add = acc && in_item.byte_present;
			end
			ST_LOAD: begin
				cmd.load_msg   = (lcnt_q != 7'd64);
				cmd.comp_start = (lcnt_q == 7'd64);
			end
			ST_ROUND: cmd.round_en = 1'b1;
			ST_DONE:  cmd.comp_done = 1'b1;
			ST_PAD: begin
				cmd.buf_wr = 1'b1;
				if (pad_first_q) begin
					cmd.wsrc = shash_pkg::WSRC_PAD;
				end else if (fill_q >= 6'd56 && !second_q) begin
					cmd.wsrc = shash_pkg::WSRC_LEN;
				end else begin
					cmd.wsrc = shash_pkg::WSRC_ZERO;
				end
			end
			ST_OUT: cmd.init_hash = out_ready && oidx_q == 3'd7;
			default: ;
		endcase
	end

	// load: addresses 0..63 are read, words shift each byte in the cycle after
	// its read; the final byte enters with comp_start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			round_q     <= '0;
			final_q     <= 1'b0;
			second_q    <= 1'b0;
			pad_first_q <= 1'b0;
			oidx_q      <= '0;
			lcnt_q      <= '0;
			pend_end_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						fill_q     <= fill_nx;
						pend_end_q <= in_item.end_of_message;
						if (in_item.byte_present && fill_q == 6'd63) begin
							state_q <= ST_LOAD;
							lcnt_q  <= '0;
						end else if (in_item.end_of_message) begin
							state_q     <= ST_PAD;
							pad_first_q <= 1'b1;
							second_q    <= (fill_nx >= 6'd56);
						end
					end
				end
				ST_PAD: begin
					pad_first_q <= 1'b0;
					fill_q      <= fill_q + 6'd1;
					if (fill_q == 6'd63) begin
						state_q <= ST_LOAD;
						lcnt_q  <= '0;
						final_q <= !second_q;
					end
				end
				ST_LOAD: begin
					lcnt_q <= lcnt_q + 7'd1;
					if (lcnt_q == 7'd64) begin
						state_q <= ST_ROUND;
						round_q <= '0;
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (second_q) begin
						second_q <= 1'b0;
						state_q  <= ST_PAD;
					end else if (final_q) begin
						final_q <= 1'b0;
						state_q <= ST_OUT;
						oidx_q  <= '0;
					end else if (pend_end_q) begin
						state_q     <= ST_PAD;
						pad_first_q <= 1'b1;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							state_q    <= ST_IDLE;
							fill_q     <= '0;
							pend_end_q <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`SHC_ASSERT_IMPL(a_ready_idle, clk, arst_n, in_ready, !out_valid)
	`SHC_ASSERT_NEXT(a_round_wrap, clk, arst_n, state_q == ST_ROUND && round_q == 6'd63, state_q == ST_DONE)
	`SHC_ASSERT_IMPL(a_out_fill, clk, arst_n, state_q == ST_OUT, fill_q == 6'd0)
endmodule
`default_nettype wire

>>> src/sha256_stream_hash_core.sv
// ---------------------------------------------------------------------------
// sha256_stream_hash_core
// SHA-256 of a byte stream, one optional byte per input transfer, eight
// digest words out after each end of message.
// ---------------------------------------------------------------------------
// Each 64th byte starts a compression (moving the block buffer into the
// schedule through its single read port, 64 rounds, one hash update),
// during which input is held off. End of message pads each final block,
// runs one or two compressions and then offers the eight digest words, one
// per transfer.
`default_nettype none
module sha256_stream_hash_core (
	input wire logic clk,
	input wire logic arst_n,
	shash_stream_if.sink   in_ch,
	shash_stream_if.source out_ch
);
	shash_pkg::dp_cmd_t cmd;
	shash_pkg::dp_sts_t sts;
	shash_pkg::in_item_t in_item;
	logic [31:0] hash_word;
	logic [2:0]  out_idx;
	logic        out_valid;
	logic        in_ready;

	assign in_item = in_ch.payload;
	assign in_ch.ready = in_ready;

	shash_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ch.ready),
		.out_idx   (out_idx),
		.cmd       (cmd),
		.sts       (sts)
	);

	shash_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.msg_byte  (in_item.msg_byte),
		.sts       (sts),
		.hash_word (hash_word)
	);

	assign out_ch.valid   = out_valid;
	assign out_ch.payload = '{digest_word: hash_word, word_index: out_idx,
		last_word: (out_idx == 3'd7)};
endmodule
`default_nettype wire
